[rtl/gpm_pkg.sv]
// ----------------------------------------------------------------------------
// GF(2^8) polynomial MAC package
// Field element type, the AES field polynomial and the field multiply.
// ----------------------------------------------------------------------------
`default_nettype none

package gpm_pkg;

   localparam int GF_WIDTH = 8;
   localparam logic [GF_WIDTH:0] FIELD_POLY = 9'h11B;
   localparam logic [GF_WIDTH-1:0] FIELD_REDUCE = FIELD_POLY[GF_WIDTH-1:0];

   typedef logic [GF_WIDTH-1:0] gf_elem_type;

   // shift-and-add multiply, reduced modulo the field polynomial
   function automatic gf_elem_type gf_mul(gf_elem_type a, gf_elem_type b);
      gf_elem_type acc;
      gf_elem_type x;
      acc = '0;
      x   = a;
      for (int i = 0; i < GF_WIDTH; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         if (x[GF_WIDTH-1]) begin
            x = gf_elem_type'(x << 1) ^ FIELD_REDUCE;
         end else begin
            x = gf_elem_type'(x << 1);
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

[rtl/gpm_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one message byte and its last-byte flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpm_req_if import gpm_pkg::*; ();
   logic        valid;
   logic        ready;
   gf_elem_type data_byte;
   logic        last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/gpm_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one finished MAC value.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpm_rsp_if import gpm_pkg::*; ();
   logic        valid;
   logic        ready;
   gf_elem_type mac_value;

   modport source (output valid, output mac_value, input ready);
   modport sink   (input valid, input mac_value, output ready);
endinterface

`default_nettype wire

[rtl/gpm_csr_if.sv]
// ----------------------------------------------------------------------------
// Key write channel
// Valid/ready channel carrying a new value of the MAC key register.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpm_csr_if import gpm_pkg::*; ();
   logic        valid;
   logic        ready;
   gf_elem_type mac_key;

   modport source (output valid, output mac_key, input ready);
   modport sink   (input valid, input mac_key, output ready);
endinterface

`default_nettype wire

[rtl/gpm_mac_core.sv]
// ----------------------------------------------------------------------------
// MAC accumulation core
// Holds the running sum, the current key power and the block-start flag,
// and folds one byte into the sum on every step.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_mac_core import gpm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire gf_elem_type data_byte,
   input  wire logic        last_byte,
   input  wire gf_elem_type mac_key,
   output gf_elem_type      mac_value
);

   gf_elem_type running_sum_ff;
   gf_elem_type running_sum_in;
   gf_elem_type key_power_ff;
   gf_elem_type key_power_in;
   logic        block_start_ff;
   logic        block_start_in;
   gf_elem_type sum_base;
   gf_elem_type power_cur;

   always_comb begin
      sum_base       = block_start_ff ? '0 : running_sum_ff;
      power_cur      = block_start_ff ? mac_key : key_power_ff;
      running_sum_in = sum_base ^ gf_mul(data_byte, power_cur);
      key_power_in   = gf_mul(power_cur, mac_key);
      block_start_in = last_byte;
      mac_value      = running_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_start_ff <= 1'b1;
      end else if (step) begin
         block_start_ff <= block_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         running_sum_ff <= running_sum_in;
         key_power_ff   <= key_power_in;
      end
   end

endmodule

`default_nettype wire

[rtl/gf256_polynomial_mac.sv]
// ----------------------------------------------------------------------------
// GF(2^8) polynomial MAC
// Byte-stream MAC: sum over GF(2^8) (poly 0x11B) of byte i times key^(i+1).
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle, stalling only while a last byte waits on a
// pending response. The byte flagged last closes the block; its MAC goes to
// the response channel via the input register, then the result register.
// The combinational pair of field multiplies in the core sets the rate. Write
// the key only while no bytes are in flight; it starts at zero after reset.
`default_nettype none

module gf256_polynomial_mac import gpm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   gpm_req_if.sink  req_chan,
   gpm_rsp_if.source rsp_chan,
   gpm_csr_if.sink  csr_chan
);

   gf_elem_type mac_key_ff;
   logic        s1_valid_ff;
   logic        s1_valid_in;
   gf_elem_type s1_data_ff;
   logic        s1_last_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   gf_elem_type rsp_mac_ff;
   gf_elem_type mac_next;
   logic        advance;
   logic        accept;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_key_ff <= '0;
      end else if (csr_chan.valid) begin
         mac_key_ff <= csr_chan.mac_key;
      end
   end

   always_comb begin
      advance        = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_chan.ready);
      req_chan.ready = !s1_valid_ff || advance;
      accept         = req_chan.valid && req_chan.ready;
      s1_valid_in    = accept || (s1_valid_ff && !advance);
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.last_byte;
      end
      if (advance && s1_last_ff) begin
         rsp_mac_ff <= mac_next;
      end
   end

   gpm_mac_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (s1_data_ff),
      .last_byte (s1_last_ff),
      .mac_key   (mac_key_ff),
      .mac_value (mac_next)
   );

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.mac_value = rsp_mac_ff;

`ifndef NO_ASSERTIONS
   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff)
      else $error("request stalled with empty input register");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("response raised without a last byte");

   a_rsp_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_mac_ff))
      else $error("pending response lost or overwritten");
`endif

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// GF(2^8) polynomial MAC testbench
// Drives message bytes, key writes and response backpressure at random, and
// scores every MAC against a field-arithmetic predictor kept in step with the
// requests the block accepts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import gpm_pkg::*;

   typedef struct packed {
      gf_elem_type data_byte;
      logic        last_byte;
   } msg_byte_type;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 6;
   localparam int DRAIN_CYCLES  = 4;
   localparam int END_CYCLES    = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 1050;
   localparam int IDLE_PCT      = 35;

   logic clock;
   logic reset;

   gpm_req_if req_chan ();
   gpm_rsp_if rsp_chan ();
   gpm_csr_if csr_chan ();

   gf256_polynomial_mac i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   msg_byte_type pending_bytes[$];
   gf_elem_type  expected_macs[$];
   gf_elem_type  key_writes[$];

   gf_elem_type mac_key_shadow = '0;
   gf_elem_type mac_sum        = '0;
   gf_elem_type key_power      = '0;
   logic        block_open_n   = 1'b1;

   int unsigned req_idle_pct = IDLE_PCT;
   int unsigned rsp_idle_pct = IDLE_PCT;
   int unsigned error_count  = 0;
   int unsigned stall_count  = 0;

   // Horner form: walk the multiplier from its top bit, doubling between bits
   function automatic gf_elem_type gf_product(gf_elem_type a, gf_elem_type b);
      gf_elem_type acc;
      acc = '0;
      for (int i = GF_WIDTH - 1; i >= 0; i--) begin
         acc = {acc[GF_WIDTH-2:0], 1'b0} ^ (acc[GF_WIDTH-1] ? FIELD_REDUCE : '0);
         if (b[i]) begin
            acc = acc ^ a;
         end
      end
      return acc;
   endfunction

   task automatic accumulate_mac(msg_byte_type req);
      if (block_open_n) begin
         key_power = mac_key_shadow;
         mac_sum   = '0;
      end
      mac_sum      = mac_sum ^ gf_product(req.data_byte, key_power);
      key_power    = gf_product(key_power, mac_key_shadow);
      block_open_n = req.last_byte;
      if (req.last_byte) begin
         expected_macs.insert(expected_macs.size(), mac_sum);
      end
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.mac_key   = '0;
      forever begin
         #(CLOCK_PERIOD / 2) clock = ~clock;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            accumulate_mac('{req_chan.data_byte, req_chan.last_byte});
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               msg_byte_type next_req;
               next_req = pending_bytes.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.data_byte <= next_req.data_byte;
               req_chan.last_byte <= next_req.last_byte;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // key write driver
   always @(posedge clock) begin
      if (reset) begin
         csr_chan.valid <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            mac_key_shadow = csr_chan.mac_key;
         end
         if (!csr_chan.valid || csr_chan.ready) begin
            if (key_writes.size() != 0) begin
               csr_chan.valid   <= 1'b1;
               csr_chan.mac_key <= key_writes.pop_front();
            end else begin
               csr_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_macs.size() == 0) begin
               error_count++;
               $display("%0t: unexpected mac, expected none, actual %02h",
                        $time, rsp_chan.mac_value);
            end else begin
               gf_elem_type want;
               want = expected_macs.pop_front();
               if (rsp_chan.mac_value !== want) begin
                  error_count++;
                  $display("%0t: mac mismatch, expected %02h, actual %02h",
                           $time, want, rsp_chan.mac_value);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, %0d macs outstanding", $time, expected_macs.size());
         $display("simulation failed");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic queue_byte(gf_elem_type data, logic last);
      msg_byte_type item;
      item.data_byte = data;
      item.last_byte = last;
      pending_bytes.insert(pending_bytes.size(), item);
   endtask

   // hold the sender until every mac has come back
   task automatic drain();
      do begin
         @(negedge clock);
      end while (pending_bytes.size() != 0 || req_chan.valid || expected_macs.size() != 0);
   endtask

   task automatic write_key(gf_elem_type key);
      repeat (DRAIN_CYCLES) @(negedge clock);
      key_writes.insert(key_writes.size(), key);
      do begin
         @(negedge clock);
      end while (key_writes.size() != 0 || csr_chan.valid);
   endtask

   initial begin : stimulus
      int unsigned total;
      int unsigned phase;
      int unsigned budget;
      int unsigned len;
      bit          leave_open;
      gf_elem_type key;

      do begin
         @(negedge clock);
      end while (reset);

      // key still zero from reset: every mac is zero
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h01, 1'b1);
      drain();

      write_key(8'h01);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h80, 1'b1);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h5A, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hC3, 1'b0);
      drain();

      // change the key with a block still open
      write_key(8'hFF);
      queue_byte(8'h3C, 1'b0);
      queue_byte(8'hA5, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'hFE, 1'b1);
      drain();

      write_key(8'h02);
      for (int k = 0; k < 8; k++) begin
         queue_byte(8'h01 << k, k == 7);
      end
      drain();

      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         case (phase % 8)
            0: key = 8'hFF;
            1: key = 8'h00;
            2: key = 8'h01;
            default: key = gf_elem_type'($urandom);
         endcase
         write_key(key);
         if (phase == 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = IDLE_PCT;
            rsp_idle_pct = IDLE_PCT;
         end
         budget = $urandom_range(60, 140);
         while (budget > 0) begin
            if ($urandom_range(9) == 0) begin
               len = $urandom_range(17, 48);
            end else begin
               len = $urandom_range(1, 8);
            end
            if (len > budget) begin
               len = budget;
            end
            budget     = budget - len;
            leave_open = (budget == 0) && ($urandom_range(2) == 0);
            for (int k = 0; k < len; k++) begin
               queue_byte(($urandom_range(7) == 0) ? 8'h00 : gf_elem_type'($urandom),
                          (k == len - 1) && !leave_open);
            end
            total = total + len;
         end
         drain();
         phase++;
      end

      repeat (END_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
